// File: sv/majority_vote_finder_macros.svh
// ----------------------------------------------------------------------------
// Majority vote finder assertion macros
// Shorthand for the concurrent checks used in the majority vote finder.
// ----------------------------------------------------------------------------
`ifndef MAJORITY_VOTE_FINDER_MACROS_SVH
`define MAJORITY_VOTE_FINDER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MVF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("majority_vote_finder: check failed");

// Next-cycle implication, disabled while reset is high.
`define MVF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("majority_vote_finder: check failed");

`endif

// File: sv/mvf_pkg.sv
// ----------------------------------------------------------------------------
// Majority vote finder package
// Request and result payload types shared by the block's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mvf_pkg;

  localparam int FIELD_W = 32;
  localparam int POS_W   = 10;

  typedef struct packed {
    logic signed [FIELD_W-1:0] item_value;
    logic                      is_last;
  } item_t;

  typedef struct packed {
    logic                      found;
    logic [POS_W-1:0]          position;
    logic signed [FIELD_W-1:0] majority_value;
    logic                      overflow;
  } result_t;

endpackage

`default_nettype wire

// File: sv/mvf_ram.sv
// ----------------------------------------------------------------------------
// Majority vote finder RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mvf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/mvf_front.sv
// ----------------------------------------------------------------------------
// Majority vote finder front end
// Accepts list requests, stores each value and runs the majority vote.
// ----------------------------------------------------------------------------
`default_nettype none

module mvf_front import mvf_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire item_t                      item,
  input  wire logic                       done,
  input  wire logic                       job_full,
  output logic                            ram_we,
  output logic [$clog2(DEPTH)-1:0]        ram_waddr,
  output logic [VALUE_WIDTH-1:0]          ram_wdata,
  output logic                            job_push,
  output logic [VALUE_WIDTH-1:0]          job_cand,
  output logic [$clog2(DEPTH+1)-1:0]      job_count,
  output logic                            job_ovf,
  output logic                            lock
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [VALUE_WIDTH-1:0] candidate, candidate_next;
  logic [CW-1:0]          vote_count, vote_count_next;
  logic [CW-1:0]          item_count, item_count_next;
  logic                   overflowed, overflowed_next;
  logic [VALUE_WIDTH-1:0] value;
  logic                   accept;
  logic                   room;

  assign item_stall = lock || job_full;
  assign accept     = item_valid && !item_stall;
  assign value      = VALUE_WIDTH'(item.item_value);
  assign room       = (item_count != CW'(DEPTH));

  always_comb begin
    candidate_next  = candidate;
    vote_count_next = vote_count;
    item_count_next = item_count;
    overflowed_next = overflowed;
    if (room) begin
      if ((item_count == '0) || (vote_count == '0)) begin
        candidate_next  = value;
        vote_count_next = CW'(1);
      end else if (candidate == value) begin
        vote_count_next = vote_count + CW'(1);
      end else begin
        vote_count_next = vote_count - CW'(1);
      end
      item_count_next = item_count + CW'(1);
    end else begin
      overflowed_next = 1'b1;
    end
  end

  assign ram_we    = accept && room;
  assign ram_waddr = item_count[AW-1:0];
  assign ram_wdata = value;

  assign job_push  = accept && item.is_last;
  assign job_cand  = candidate_next;
  assign job_count = item_count_next;
  assign job_ovf   = overflowed_next;

  // The store stays locked from the last request of a list until the walk
  // over it has finished, so the next list cannot overwrite it.
  always_ff @(posedge clk) begin
    if (rst) begin
      candidate  <= '0;
      vote_count <= '0;
      item_count <= '0;
      overflowed <= 1'b0;
      lock       <= 1'b0;
    end else begin
      if (accept) begin
        if (item.is_last) begin
          candidate  <= '0;
          vote_count <= '0;
          item_count <= '0;
          overflowed <= 1'b0;
          lock       <= 1'b1;
        end else begin
          candidate  <= candidate_next;
          vote_count <= vote_count_next;
          item_count <= item_count_next;
          overflowed <= overflowed_next;
        end
      end
      if (done) begin
        lock <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/mvf_queue.sv
// ----------------------------------------------------------------------------
// Majority vote finder job queue
// Two-entry FIFO that carries finished votes from the front to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mvf_queue #(
  parameter int WIDTH = 44
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic      [WIDTH-1:0] head
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign head    = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/mvf_back.sv
// ----------------------------------------------------------------------------
// Majority vote finder back end
// Walks the stored list to verify the candidate and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mvf_back import mvf_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       job_valid,
  output logic                            job_pop,
  input  wire logic [VALUE_WIDTH-1:0]     job_cand,
  input  wire logic [$clog2(DEPTH+1)-1:0] job_count,
  input  wire logic                       job_ovf,
  output logic                            ram_re,
  output logic [$clog2(DEPTH)-1:0]        ram_raddr,
  input  wire logic [VALUE_WIDTH-1:0]     ram_rdata,
  output logic                            done,
  output logic                            busy,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output result_t                         result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] cand;
  logic [CW-1:0]          n;
  logic [CW-1:0]          thr;
  logic                   ovf;
  logic [CW-1:0]          iss;
  logic                   pend;
  logic [AW-1:0]          pend_idx;
  logic [CW-1:0]          hits;
  logic [CW-1:0]          hits_new;
  logic                   found;
  logic [AW-1:0]          pos;
  logic                   out_free;
  logic [CW:0]            n_plus;

  assign out_free  = !result_valid || !result_stall;
  assign job_pop   = (state == S_IDLE) && job_valid;
  assign ram_re    = (state == S_WALK) && (iss != n);
  assign ram_raddr = iss[AW-1:0];
  assign done      = (state == S_DONE) && out_free;
  assign busy      = (state != S_IDLE);
  assign hits_new  = hits + CW'(ram_rdata == cand);
  assign n_plus    = {1'b0, job_count} + (CW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (done) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      pend <= ram_re;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= job_ovf ? S_DONE : S_WALK;
          end
        end
        S_WALK: begin
          // Read data of the index issued last cycle is checked here.
          if (pend) begin
            if (hits_new > thr) begin
              state <= S_DONE;
            end else if (pend_idx == AW'(n - CW'(1))) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cand  <= job_cand;
      n     <= job_count;
      thr   <= n_plus[CW:1];
      ovf   <= job_ovf;
      iss   <= '0;
      hits  <= '0;
      found <= 1'b0;
      pos   <= '0;
    end
    if (ram_re) begin
      iss      <= iss + CW'(1);
      pend_idx <= iss[AW-1:0];
    end
    if ((state == S_WALK) && pend) begin
      hits <= hits_new;
      if (hits_new > thr) begin
        found <= 1'b1;
        pos   <= pend_idx;
      end
    end
    if (done) begin
      result.found          <= found;
      result.position       <= found ? POS_W'(pos) : '0;
      result.majority_value <= found ? FIELD_W'(signed'(cand)) : '0;
      result.overflow       <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: sv/majority_vote_finder.sv
// ----------------------------------------------------------------------------
// Majority vote finder
// Boyer-Moore majority vote over a list, verified by a walk of the stored list.
// ----------------------------------------------------------------------------
// List values load at one request per cycle while the item channel is not
// stalled: each is written to the value store and fed to the vote in the same
// cycle. The request with is_last set hands the candidate to the verify engine
// through a short job queue, and the item channel then stalls until that list's
// result has been placed in the output register. The walk reads the store
// through its single read port, one entry per cycle, and stops early when the
// majority is confirmed; an overflowed list skips the walk. The store needs no
// clearing pass after reset. Values past DEPTH entries are dropped and the
// result reports overflow.
// ----------------------------------------------------------------------------
`default_nettype none

`include "majority_vote_finder_macros.svh"

module majority_vote_finder import mvf_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int JW = VALUE_WIDTH + CW + 1;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic                   job_push;
  logic [VALUE_WIDTH-1:0] push_cand;
  logic [CW-1:0]          push_count;
  logic                   push_ovf;
  logic                   job_full;
  logic                   job_pop;
  logic                   job_valid;
  logic [JW-1:0]          job_head;

  logic                   done;
  logic                   busy;
  logic                   lock;

  mvf_front #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .done       (done),
    .job_full   (job_full),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .job_push   (job_push),
    .job_cand   (push_cand),
    .job_count  (push_count),
    .job_ovf    (push_ovf),
    .lock       (lock)
  );

  mvf_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data ({push_cand, push_count, push_ovf}),
    .full      (job_full),
    .pop       (job_pop),
    .valid     (job_valid),
    .head      (job_head)
  );

  mvf_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mvf_back #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_pop      (job_pop),
    .job_cand     (job_head[JW-1:CW+1]),
    .job_count    (job_head[CW:1]),
    .job_ovf      (job_head[0]),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .done         (done),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `MVF_ASSERT_IMP(a_no_write_during_walk, clk, rst, ram_we, !busy && !lock)
  `MVF_ASSERT_IMP(a_walk_holds_lock, clk, rst, busy, lock)
  `MVF_ASSERT_NEXT(a_done_gives_result, clk, rst, done, result_valid && !lock)
  `MVF_ASSERT_IMP(a_found_not_overflow, clk, rst, result_valid && result.found,
                  !result.overflow)

endmodule

`default_nettype wire

// File: test/tb_majority_vote_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Majority vote finder testbench
// A short table of hand-picked lists comes first. Random lists follow in
// four flow-control phases, with one list that overflows the store. Every
// result is checked against a fixed table value or a local vote/verify model.
// ----------------------------------------------------------------------------

module tb_majority_vote_finder;
  import mvf_pkg::*;

  localparam int LIST_DEPTH   = 1024;
  localparam int DIR_ROWS     = 25;
  localparam int PHASE_ITEMS  = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 64;

  localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SOME = 47;
  localparam int IDLE_BOTH = 32;

  typedef struct {
    item_t   req;
    bit      fixed;
    result_t want;
  } vote_row_t;

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // Flow control knobs, set per phase by the stimulus process.
  int unsigned send_idle_pct  = IDLE_NONE;
  int unsigned recv_stall_pct = IDLE_NONE;
  bit          hold_ask       = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned errors         = 0;

  result_t expected_results [$];

  // Local copy of the block's state.
  logic [FIELD_W-1:0] shadow_store [LIST_DEPTH];
  logic [FIELD_W-1:0] cand_value   = '0;
  logic [10:0]        cand_votes   = '0;
  logic [10:0]        stored_count = '0;
  bit                 dropped      = 1'b0;

  vote_row_t vote_rows [DIR_ROWS] = '{
    // A lone value after reset never beats the threshold.
    '{'{32'sd0, 1'b1}, 1'b1, '{1'b0, 10'd0, 32'sd0, 1'b0}},
    '{'{VAL_MIN, 1'b0}, 1'b0, '0},
    '{'{VAL_MIN, 1'b1}, 1'b1, '{1'b1, 10'd1, VAL_MIN, 1'b0}},
    '{'{VAL_MAX, 1'b0}, 1'b0, '0},
    '{'{VAL_MAX, 1'b1}, 1'b1, '{1'b1, 10'd1, VAL_MAX, 1'b0}},
    // Candidate reaches the threshold but not past it, except in the 7, 7, 7 list.
    '{'{-32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'sd5, 1'b0}, 1'b0, '0},
    '{'{-32'sd1, 1'b1}, 1'b0, '0},
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd7, 1'b1}, 1'b0, '0},
    '{'{32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'sd2, 1'b0}, 1'b0, '0},
    '{'{32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'sd2, 1'b1}, 1'b0, '0},
    // In the first list the vote count drops to zero and a new candidate takes over.
    '{'{32'sd9, 1'b0}, 1'b0, '0},
    '{'{32'sd8, 1'b0}, 1'b0, '0},
    '{'{32'sd8, 1'b0}, 1'b0, '0},
    '{'{32'sd8, 1'b1}, 1'b0, '0},
    '{'{32'sd3, 1'b0}, 1'b0, '0},
    '{'{32'sd3, 1'b0}, 1'b0, '0},
    '{'{32'sd4, 1'b0}, 1'b0, '0},
    '{'{32'sd3, 1'b0}, 1'b0, '0},
    '{'{32'sd3, 1'b1}, 1'b0, '0},
    '{'{VAL_MIN, 1'b1}, 1'b1, '{1'b0, 10'd0, 32'sd0, 1'b0}}
  };

  majority_vote_finder #(
    .DEPTH       (LIST_DEPTH),
    .VALUE_WIDTH (FIELD_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Runs the vote on one request and, on the last one, the verify walk.
  function automatic bit vote_and_verify(input item_t req, output result_t res);
    logic [10:0] threshold;
    logic [10:0] hits;
    logic [FIELD_W-1:0] v;
    v = req.item_value;
    res = '0;
    if (stored_count < LIST_DEPTH) begin
      shadow_store[stored_count] = v;
      if (stored_count == 0 || cand_votes == 0) begin
        cand_value = v;
        cand_votes = 11'd1;
      end else if (cand_value == v) begin
        cand_votes = cand_votes + 11'd1;
      end else begin
        cand_votes = cand_votes - 11'd1;
      end
      stored_count = stored_count + 11'd1;
    end else begin
      dropped = 1'b1;
    end
    if (!req.is_last) return 1'b0;
    res.overflow = dropped;
    if (!dropped) begin
      threshold = (stored_count + 11'd1) / 11'd2;
      hits = '0;
      for (int i = 0; i < stored_count; i++) begin
        if (shadow_store[i] == cand_value) hits = hits + 11'd1;
        if (hits > threshold) begin
          res.found          = 1'b1;
          res.position       = i[POS_W-1:0];
          res.majority_value = cand_value;
          break;
        end
      end
    end
    cand_value   = '0;
    cand_votes   = '0;
    stored_count = '0;
    dropped      = 1'b0;
    return 1'b1;
  endfunction

  // Offers one request, waits for it to be taken, then records what it should produce.
  task automatic feed(input item_t req, input bit fixed, input result_t want);
    result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (vote_and_verify(req, got)) expected_results.push_back(fixed ? want : got);
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4, 5:    return $signed($urandom_range(0, 7)) - 32'sd4;
      default: return $signed($urandom());
    endcase
  endfunction

  // Biased lists repeat one value in 30 to 95 percent of requests; the others are noise.
  task automatic run_list(input int unsigned len, input bit biased);
    item_t req;
    logic signed [FIELD_W-1:0] dominant;
    int unsigned share;
    dominant = pick_value();
    share = biased ? $urandom_range(30, 95) : 0;
    for (int unsigned i = 0; i < len; i++) begin
      req.item_value = ($urandom_range(0, 99) < share) ? dominant : pick_value();
      req.is_last    = (i == len - 1);
      feed(req, 1'b0, '0);
    end
  endtask

  // Result side: check each accepted result, then choose the next stall.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, result.found);
            errors++;
          end
          if (result.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, result.position);
            errors++;
          end
          if (result.majority_value !== want.majority_value) begin
            $error("majority_value: expected %0d, got %0d",
                   want.majority_value, result.majority_value);
            errors++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, result.overflow);
            errors++;
          end
        end
      end
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
      if (hold_left != 0) hold_left--;
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned phase_items;
    int unsigned len;
    int unsigned pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      feed(vote_rows[r].req, vote_rows[r].fixed, vote_rows[r].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = IDLE_NONE; recv_stall_pct = IDLE_NONE; end
        1: begin send_idle_pct = IDLE_SOME; recv_stall_pct = IDLE_NONE; end
        2: begin send_idle_pct = IDLE_NONE; recv_stall_pct = IDLE_SOME; end
        default: begin send_idle_pct = IDLE_BOTH; recv_stall_pct = IDLE_BOTH; end
      endcase
      // Hold the result side off long enough for the item side to back up.
      if (phase == 2) hold_ask = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      len = $urandom_range(1, 8);
        else if (pick < 90) len = $urandom_range(9, 40);
        else if (pick < 99) len = $urandom_range(41, 120);
        else                len = $urandom_range(121, 250);
        run_list(len, $urandom_range(0, 99) < 80);
        phase_items += len;
      end
      // A list one longer than the store, so that its last request is dropped.
      if (phase == 3) run_list(LIST_DEPTH + 1, 1'b1);
    end

    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
